@@ sv/npc_pkg.sv @@
// npc_pkg: shared constants, codes and types of the nibble prefix code packer
// used by every module of the block; no dependencies
package npc_pkg;

    localparam int NUM_SYMBOLS  = 16;
    localparam int NUM_CODES    = NUM_SYMBOLS + 1;
    localparam int STOP_INDEX   = NUM_SYMBOLS;
    localparam int CODE_BITS    = 8;
    localparam int LEN_BITS     = 4;
    localparam int NIBBLE_BITS  = 4;
    localparam int CODE_SPACE   = 1 << CODE_BITS;
    localparam int TOTAL_BITS   = 12;
    localparam int CODE_IDX_BITS = $clog2(NUM_CODES);
    localparam int CFG_BITS     = NUM_SYMBOLS * LEN_BITS;
    localparam int QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_CODE      = 2'd0,
        OP_CODE_STOP = 2'd1,
        OP_STOP      = 2'd2,
        OP_FLUSH     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_XOR  = 2'd1,
        MODE_SUB  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CFG_SYMBOL_LENGTHS = 2'd0,
        CFG_STOP_LENGTH    = 2'd1,
        CFG_TRANSFORM_MODE = 2'd2
    } t_cfg_idx;

    typedef logic [NUM_CODES-1:0][LEN_BITS-1:0]  t_len_arr;
    typedef logic [NUM_CODES-1:0][CODE_BITS-1:0] t_word_arr;

    // one classified request: up to two codes to append, or a flush, or an error
    typedef struct packed {
        logic                 err;
        logic                 flush;
        logic [LEN_BITS-1:0]  size1;
        logic [CODE_BITS-1:0] word1;
        logic [LEN_BITS-1:0]  size2;
        logic [CODE_BITS-1:0] word2;
    } t_job;

endpackage

@@ sv/npc_table.sv @@
// npc_table: code length registers and the code table builder
// depends on npc_pkg
module npc_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_lens_we,
    input  logic                          i_stop_we,
    input  logic [npc_pkg::CFG_BITS-1:0]  i_cfg_data,
    output npc_pkg::t_len_arr             o_lens,
    output npc_pkg::t_word_arr            o_words,
    output logic                          o_valid,
    output logic                          o_busy
);
    import npc_pkg::*;

    logic [CFG_BITS-1:0]      r_sym_lengths;
    logic [LEN_BITS-1:0]      r_stop_length;
    logic                     r_busy;
    logic                     r_bad;
    logic [TOTAL_BITS-1:0]    r_total;
    logic [CODE_IDX_BITS-1:0] r_step;
    t_word_arr                r_word;

    logic                     start;
    logic [LEN_BITS-1:0]      cur_len;
    logic [CODE_BITS-1:0]     inc;
    logic                     cur_bad;
    logic [NUM_CODES-1:0]     ahead;

    always_comb begin
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
            o_lens[i] = r_sym_lengths[(NUM_SYMBOLS-1-i)*LEN_BITS +: LEN_BITS];
        end
        o_lens[STOP_INDEX] = r_stop_length;
    end

    assign start   = i_lens_we || i_stop_we;
    assign cur_len = o_lens[r_step];
    assign cur_bad = cur_len > LEN_BITS'(CODE_BITS);
    // weight of one code in the 2^CODE_BITS code space
    assign inc     = (cur_len == '0 || cur_bad) ? '0
                   : CODE_BITS'(1) << (LEN_BITS'(CODE_BITS) - cur_len);

    // code j sits ahead of code i: longer, or same length and lower index
    always_comb begin
        for (int i = 0; i < NUM_CODES; i++) begin
            ahead[i] = (cur_len > o_lens[i]) ||
                       (cur_len == o_lens[i] && r_step < CODE_IDX_BITS'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lengths <= '0;
            r_stop_length <= '0;
            r_busy        <= 1'b0;
            r_bad         <= 1'b0;
            r_total       <= '0;
            r_step        <= '0;
        end else begin
            if (i_lens_we) begin
                r_sym_lengths <= i_cfg_data;
            end
            if (i_stop_we) begin
                r_stop_length <= i_cfg_data[LEN_BITS-1:0];
            end
            if (start) begin
                r_busy  <= 1'b1;
                r_bad   <= 1'b0;
                r_total <= '0;
                r_step  <= '0;
            end else if (r_busy) begin
                r_total <= r_total + TOTAL_BITS'(inc);
                r_bad   <= r_bad || cur_bad;
                r_step  <= r_step + 1'b1;
                if (r_step == CODE_IDX_BITS'(NUM_CODES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one lane per code, each accumulating the weights of the codes ahead of it
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_CODES; i++) begin
            if (start) begin
                r_word[i] <= '0;
            end else if (r_busy && ahead[i]) begin
                r_word[i] <= r_word[i] + inc;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CODES; i++) begin
            o_words[i] = (o_lens[i] == '0) ? '0 : r_word[i];
        end
    end

    assign o_valid = !r_busy && !r_bad && r_total == TOTAL_BITS'(CODE_SPACE);
    assign o_busy  = r_busy;

endmodule

@@ sv/npc_front.sv @@
// npc_front: accepts requests, applies the nibble transform, looks up codes
// depends on npc_pkg
module npc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_mode_we,
    input  logic [1:0]                       i_mode_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [npc_pkg::NIBBLE_BITS-1:0]  i_nibble,
    input  npc_pkg::t_len_arr                i_lens,
    input  npc_pkg::t_word_arr               i_words,
    input  logic                             i_table_valid,
    input  logic                             i_table_busy,
    input  logic                             i_q_ready,
    output logic                             o_push,
    output npc_pkg::t_job                    o_job
);
    import npc_pkg::*;

    logic [1:0]                r_mode;
    logic [NIBBLE_BITS-1:0]    r_prev;

    logic [NIBBLE_BITS-1:0]    sym;
    logic [CODE_IDX_BITS-1:0]  sym_idx;
    logic                      accept;
    logic                      uses_nibble;
    t_opcode                   op;

    assign op         = t_opcode'(i_opcode);
    assign o_in_ready = !i_table_busy && i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;
    assign uses_nibble = (op == OP_CODE) || (op == OP_CODE_STOP);

    always_comb begin
        unique case (r_mode)
            MODE_XOR: sym = r_prev ^ i_nibble;
            MODE_SUB: sym = r_prev - i_nibble;
            default:  sym = i_nibble;
        endcase
    end

    assign sym_idx = CODE_IDX_BITS'(sym);

    always_comb begin
        o_job = '0;
        if (!i_table_valid) begin
            o_job.err = 1'b1;
        end else begin
            unique case (op)
                OP_CODE: begin
                    o_job.size1 = i_lens[sym_idx];
                    o_job.word1 = i_words[sym_idx];
                end
                OP_CODE_STOP: begin
                    o_job.size1 = i_lens[sym_idx];
                    o_job.word1 = i_words[sym_idx];
                    o_job.size2 = i_lens[STOP_INDEX];
                    o_job.word2 = i_words[STOP_INDEX];
                end
                OP_STOP: begin
                    o_job.size2 = i_lens[STOP_INDEX];
                    o_job.word2 = i_words[STOP_INDEX];
                end
                OP_FLUSH: begin
                    o_job.flush = 1'b1;
                end
                default: begin
                    o_job.flush = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_prev <= '0;
        end else begin
            if (i_mode_we) begin
                r_mode <= i_mode_data;
            end
            if (accept && i_table_valid && uses_nibble) begin
                r_prev <= i_nibble;
            end
        end
    end

endmodule

@@ sv/npc_queue.sv @@
// npc_queue: small request queue between the front and the back
// depends on npc_pkg
module npc_queue #(
    parameter int DEPTH = npc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  npc_pkg::t_job  i_job,
    output logic           o_ready,
    output logic           o_valid,
    output npc_pkg::t_job  o_job,
    input  logic           i_pop
);
    import npc_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_job                 r_mem [DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = r_count != CNT_BITS'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] ptr);
        return (ptr == PTR_BITS'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/npc_back.sv @@
// npc_back: bit packer and output register with one spare byte slot
// depends on npc_pkg
module npc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    input  npc_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [npc_pkg::CODE_BITS-1:0] o_packed_byte,
    output logic                          o_table_error,
    output logic                          o_last
);
    import npc_pkg::*;

    localparam int STREAM_BITS = 3 * CODE_BITS;
    localparam int FILL_BITS   = $clog2(CODE_BITS);
    localparam int SUM_BITS    = $clog2(STREAM_BITS);

    logic [CODE_BITS-1:0]   r_acc,   n_acc;
    logic [FILL_BITS-1:0]   r_fill,  n_fill;
    logic                   r_out_valid, n_out_valid;
    logic [CODE_BITS-1:0]   r_out_byte,  n_out_byte;
    logic                   r_out_err,   n_out_err;
    logic                   r_out_last,  n_out_last;
    logic                   r_pend_valid, n_pend_valid;
    logic [CODE_BITS-1:0]   r_pend_byte,  n_pend_byte;

    logic                   out_free;
    logic [STREAM_BITS-1:0] stream;
    logic [SUM_BITS-1:0]    shift2;
    logic [SUM_BITS-1:0]    total;
    logic [1:0]             nbytes;
    logic [CODE_BITS-1:0]   byte0;
    logic [CODE_BITS-1:0]   byte1;
    logic [CODE_BITS-1:0]   job_acc;
    logic [FILL_BITS-1:0]   job_fill;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_job_valid && !r_pend_valid && out_free;

    // pending bits followed by both codes, MSB aligned
    assign shift2 = SUM_BITS'(r_fill) + SUM_BITS'(i_job.size1);
    assign total  = shift2 + SUM_BITS'(i_job.size2);
    assign stream = {r_acc, {(2*CODE_BITS){1'b0}}}
                  | ({i_job.word1, {(2*CODE_BITS){1'b0}}} >> r_fill)
                  | ({i_job.word2, {(2*CODE_BITS){1'b0}}} >> shift2);

    always_comb begin
        nbytes   = 2'd0;
        byte0    = stream[STREAM_BITS-1 -: CODE_BITS];
        byte1    = stream[2*CODE_BITS-1 -: CODE_BITS];
        job_acc  = r_acc;
        job_fill = r_fill;
        if (i_job.err) begin
            nbytes = 2'd1;
            byte0  = '0;
        end else if (i_job.flush) begin
            nbytes   = (r_fill != '0) ? 2'd1 : 2'd0;
            byte0    = r_acc;
            job_acc  = '0;
            job_fill = '0;
        end else begin
            job_fill = total[FILL_BITS-1:0];
            if (total >= SUM_BITS'(2 * CODE_BITS)) begin
                nbytes  = 2'd2;
                job_acc = stream[CODE_BITS-1:0];
            end else if (total >= SUM_BITS'(CODE_BITS)) begin
                nbytes  = 2'd1;
                job_acc = stream[2*CODE_BITS-1 -: CODE_BITS];
            end else begin
                job_acc = stream[STREAM_BITS-1 -: CODE_BITS];
            end
        end
    end

    always_comb begin
        n_acc        = r_acc;
        n_fill       = r_fill;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_byte   = r_out_byte;
        n_out_err    = r_out_err;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        if (r_pend_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_out_byte   = r_pend_byte;
            n_out_err    = 1'b0;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end else if (o_pop) begin
            n_acc  = job_acc;
            n_fill = job_fill;
            if (nbytes != 2'd0) begin
                n_out_valid = 1'b1;
                n_out_byte  = byte0;
                n_out_err   = i_job.err;
                n_out_last  = nbytes == 2'd1;
            end
            if (nbytes == 2'd2) begin
                n_pend_valid = 1'b1;
                n_pend_byte  = byte1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_fill       <= n_fill;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_err   <= n_out_err;
        r_out_last  <= n_out_last;
        r_pend_byte <= n_pend_byte;
    end

    assign o_out_valid   = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_table_error = r_out_err;
    assign o_last        = r_out_last;

endmodule

@@ sv/nibble_prefix_code_packer.sv @@
// nibble_prefix_code_packer: top level of the nibble prefix code packer
// depends on npc_pkg, npc_table, npc_front, npc_queue, npc_back
//
// usage
// - input channel (i_in_valid / o_in_ready) carries one request: an opcode
//   (code nibble, code nibble then stop, stop only, flush) and a nibble
// - output channel (o_out_valid / i_out_ready) carries packed bytes, MSB
//   first; o_last marks the final byte of a request, o_table_error flags a
//   table that is not a full prefix code (byte zero, one byte per request)
// - config port writes symbol lengths, stop length or transform mode
// - an accepted request passes the request queue, then the output register
// - throughput: one request per cycle while the receiver is ready and each
//   yields at most one byte; a second byte in the spare slot stalls the queue
// - a write of symbol or stop lengths starts a table build, one code a cycle
//   through the running-offset lanes; o_in_ready stays low meanwhile
// - reset clears the lengths, so the table reads invalid until written;
//   previous nibble and the bit accumulator clear to zero
// - a stalled receiver fills the output register, then the request queue,
//   after which o_in_ready drops
module nibble_prefix_code_packer #(
    parameter int QUEUE_DEPTH = npc_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [npc_pkg::CFG_BITS-1:0]     i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_opcode,
    input  logic [npc_pkg::NIBBLE_BITS-1:0]  i_nibble,
    // byte channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [npc_pkg::CODE_BITS-1:0]    o_packed_byte,
    output logic                             o_table_error,
    output logic                             o_last
);
    import npc_pkg::*;

    // config decode
    logic      lens_we;
    logic      stop_we;
    logic      mode_we;

    t_len_arr  lens;
    t_word_arr words;
    logic      table_valid;
    logic      table_busy;

    logic      q_ready;
    logic      push;
    t_job      push_job;
    logic      q_valid;
    t_job      q_job;
    logic      pop;

    assign lens_we = i_cfg_we && i_cfg_index == CFG_SYMBOL_LENGTHS;
    assign stop_we = i_cfg_we && i_cfg_index == CFG_STOP_LENGTH;
    assign mode_we = i_cfg_we && i_cfg_index == CFG_TRANSFORM_MODE;

    // code table: lengths and words, rebuilt after each length write
    npc_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lens_we  (lens_we),
        .i_stop_we  (stop_we),
        .i_cfg_data (i_cfg_data),
        .o_lens     (lens),
        .o_words    (words),
        .o_valid    (table_valid),
        .o_busy     (table_busy)
    );

    // front: accept, transform against previous nibble, code lookup
    npc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode_we     (mode_we),
        .i_mode_data   (i_cfg_data[1:0]),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_nibble      (i_nibble),
        .i_lens        (lens),
        .i_words       (words),
        .i_table_valid (table_valid),
        .i_table_busy  (table_busy),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_job         (push_job)
    );

    // decouples lookup from packing so either side can stall
    npc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // back: bit accumulator and byte output
    npc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_packed_byte (o_packed_byte),
        .o_table_error (o_table_error),
        .o_last        (o_last)
    );

endmodule

@@ sv/npc_checker.sv @@
// npc_checker: port-level checks of the nibble prefix code packer, bound to the top
// depends on npc_pkg and nibble_prefix_code_packer
module npc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [1:0]                       i_cfg_index,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [npc_pkg::CODE_BITS-1:0]    o_packed_byte,
    input logic                             o_table_error,
    input logic                             o_last
);
    import npc_pkg::*;

    // stalled byte stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // error result is a lone zero byte
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_error |-> o_packed_byte == '0 && o_last)
        else $error("table error result malformed");

    // a length write blocks requests while the table rebuilds
    a_build_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_cfg_we &&
        (i_cfg_index == CFG_SYMBOL_LENGTHS || i_cfg_index == CFG_STOP_LENGTH)
        |=> !o_in_ready)
        else $error("request accepted during table build");

    // the second byte of a request follows right after the first
    a_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("second byte of a request missing");

endmodule

bind nibble_prefix_code_packer npc_checker u_npc_checker (.*);
